/* hw/rtl/rdc_pkg.sv */
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int MAX_DIGITS_DEF = 32;

    localparam int VALUE_W  = 31;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 4;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);

    // dividend register and bits retired per division beat
    localparam int DIV_W     = 32;
    localparam int STEP_BITS = 8;
    localparam int DIV_BEATS = DIV_W / STEP_BITS;
    localparam int BEAT_W    = $clog2(DIV_BEATS);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } rdc_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic pop;
    } rdc_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic quo_zero;
        logic count_zero;
        logic out_free;
    } rdc_sts_t;

endpackage

/* hw/rtl/rdc_dpath.sv */
`timescale 1ns / 1ps

module rdc_dpath #(
    parameter int MaxDigits = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [rdc_pkg::RADIX_W-1:0]       cfg_wdata,
    input  logic [rdc_pkg::VALUE_W-1:0]       s_value,
    input  logic                              m_tready,
    input  rdc_pkg::rdc_cmd_t                 cmd,
    output rdc_pkg::rdc_sts_t                 sts,
    output logic                              m_valid,
    output logic [rdc_pkg::DIGIT_W-1:0]       m_digit,
    output logic                              m_last
);
    import rdc_pkg::*;

    localparam int CNT_W  = $clog2(MaxDigits + 1);
    localparam int ADDR_W = $clog2(MaxDigits);

    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   eff_radix;
    logic [DIV_W-1:0]     val_reg;
    logic [DIV_W-1:0]     val_step;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_step;
    logic [DIGIT_W:0]     trial;
    logic [STEP_BITS-1:0] qbits;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_dec;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 store_room;
    logic [DIGIT_W-1:0]   digit_reg;
    logic                 last_reg;
    logic                 valid_reg;

    logic [DIGIT_W-1:0]   store [MaxDigits];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wen) begin
            radix_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    // restoring division, remainder stays below the radix
    always_comb begin
        rem_step = rem_reg;
        trial    = '0;
        qbits    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_step, val_reg[DIV_W-1-i]};
            if (trial >= {1'b0, eff_radix}) begin
                qbits[STEP_BITS-1-i] = 1'b1;
                rem_step = DIGIT_W'(trial - {1'b0, eff_radix});
            end else begin
                qbits[STEP_BITS-1-i] = 1'b0;
                rem_step = trial[DIGIT_W-1:0];
            end
        end
    end

    // quotient bits fill in from the bottom as dividend bits leave the top
    assign val_step   = {val_reg[DIV_W-STEP_BITS-1:0], qbits};
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign rd_addr    = cnt_dec[ADDR_W-1:0];
    assign store_room = (cnt_reg < CNT_W'(MaxDigits));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= {{(DIV_W-VALUE_W){1'b0}}, s_value};
            rem_reg <= '0;
        end else if (cmd.step) begin
            val_reg <= val_step;
            rem_reg <= cmd.push ? '0 : rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.push && store_room) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            cnt_reg <= cnt_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && store_room) begin
            store[cnt_reg[ADDR_W-1:0]] <= rem_step;
        end
    end

    // read data register doubles as the output word
    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            digit_reg <= store[rd_addr];
            last_reg  <= (cnt_dec == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign sts.in_zero    = (s_value == '0);
    assign sts.quo_zero   = (val_step == '0);
    assign sts.count_zero = (cnt_reg == '0);
    assign sts.out_free   = !valid_reg || m_tready;

    assign m_valid = valid_reg;
    assign m_digit = digit_reg;
    assign m_last  = last_reg;

endmodule

/* hw/rtl/rdc_ctrl.sv */
`timescale 1ns / 1ps

module rdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rdc_pkg::rdc_sts_t sts,
    output rdc_pkg::rdc_cmd_t cmd
);
    import rdc_pkg::*;

    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(DIV_BEATS - 1);

    rdc_state_t        state_reg;
    rdc_state_t        state_next;
    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] beat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            beat_reg  <= '0;
        end else begin
            state_reg <= state_next;
            beat_reg  <= beat_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !sts.in_zero) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (beat_reg == BEAT_LAST && sts.quo_zero) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.count_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        beat_next = beat_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid;
                beat_next = '0;
            end
            ST_DIV: begin
                cmd.step  = 1'b1;
                cmd.push  = (beat_reg == BEAT_LAST);
                beat_next = beat_reg + BEAT_W'(1);
            end
            ST_EMIT: begin
                cmd.pop = !sts.count_zero && sts.out_free;
            end
            default: begin
                beat_next = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/radix_digit_conversion_unit.sv */
`timescale 1ns / 1ps
// conversion: the divider passes over the whole dividend once per digit, and the
// first digit word is valid only after every digit of the value is in the store
// flow: one value at a time, set by the 8-bit-per-cycle divider and the
// one-read-per-cycle digit store pop, which waits while the output word is held
// a zero value is taken in the idle state and gives no word
// reset: aresetn, synchronous, active low; radix returns to 2, output empties
module radix_digit_conversion_unit #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [rdc_pkg::RADIX_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rdc_pkg::S_TDATA_W-1:0]     s_tdata,   // value[30:0], pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdc_pkg::M_TDATA_W-1:0]     m_tdata,   // digit[3:0], pad
    output logic                              m_tlast
);
    import rdc_pkg::*;

    rdc_cmd_t           cmd;
    rdc_sts_t           sts;
    logic [DIGIT_W-1:0] m_digit;

    rdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdc_dpath #(
        .MaxDigits (MAX_DIGITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_value   (s_tdata[VALUE_W-1:0]),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_tvalid),
        .m_digit   (m_digit),
        .m_last    (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-DIGIT_W){1'b0}}, m_digit};

`ifndef ASSERT_OFF
    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (!m_tvalid || m_tready))
        else $error("digit popped while output word still held");

    a_pop_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !sts.count_zero)
        else $error("digit popped from empty store");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DIGIT_W-1:0] <= DIGIT_W'(9)))
        else $error("digit out of range");

    a_nonzero_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !sts.in_zero) |=> !s_tready)
        else $error("nonzero value did not start a conversion");
`endif

endmodule
